// ----- rtl/htok_pkg.sv -----
// Shared types, codes and constants for the HTTP request tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package htok_pkg;

  // default field limits
  localparam int METHOD_MAX_DEF   = 7;
  localparam int URL_MAX_DEF      = 31;
  localparam int PROTOCOL_MAX_DEF = 11;
  localparam int QUERY_MAX_DEF    = 23;
  localparam int QUERY_SLOTS_DEF  = 8;
  localparam int HEADER_MAX_DEF   = 127;

  // field kinds
  localparam logic [2:0] KIND_NONE       = 3'd0;
  localparam logic [2:0] KIND_METHOD     = 3'd1;
  localparam logic [2:0] KIND_URL        = 3'd2;
  localparam logic [2:0] KIND_URL_QUERY  = 3'd3;
  localparam logic [2:0] KIND_PROTOCOL   = 3'd4;
  localparam logic [2:0] KIND_KEY        = 3'd5;
  localparam logic [2:0] KIND_VALUE      = 3'd6;
  localparam logic [2:0] KIND_BODY_QUERY = 3'd7;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_METHOD     = 3'd1;
  localparam logic [2:0] ERR_URL        = 3'd2;
  localparam logic [2:0] ERR_URL_QUERY  = 3'd3;
  localparam logic [2:0] ERR_PROTOCOL   = 3'd4;
  localparam logic [2:0] ERR_KEY        = 3'd5;
  localparam logic [2:0] ERR_VALUE      = 3'd6;
  localparam logic [2:0] ERR_BODY_QUERY = 3'd7;

  // number parser radix modes
  localparam logic [2:0] RX_START = 3'd0;
  localparam logic [2:0] RX_SIGN  = 3'd1;
  localparam logic [2:0] RX_ZERO  = 3'd2;
  localparam logic [2:0] RX_HEX0  = 3'd3;
  localparam logic [2:0] RX_DEC   = 3'd4;
  localparam logic [2:0] RX_OCT   = 3'd5;
  localparam logic [2:0] RX_HEX   = 3'd6;
  localparam logic [2:0] RX_STOP  = 3'd7;

  // delimiters
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [3:0] LEN_KEY_SIZE = 4'd14;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  field_kind;
    logic [7:0]  field_byte;
    logic [2:0]  query_slot;
    logic        field_end;
    logic        request_done;
    logic [2:0]  error_code;
    logic [31:0] body_length;
  } tok_item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] accum;
    logic        negative;
  } num_state_t;

  // "Content-Length", one character per position
  function automatic logic [7:0] len_key_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = "C";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "L";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/htok_num.sv -----
// Content-Length number parser: one character step of signed base-0 parsing.
`timescale 1ns / 1ps
`default_nettype none

module htok_num
  import htok_pkg::*;
(
  input  num_state_t cur,
  input  logic [7:0] ch,
  output num_state_t upd
);

  logic        is_dec;
  logic        is_oct;
  logic        is_hex;
  logic [3:0]  dval;
  logic [35:0] prod;
  logic [35:0] sum;
  logic [31:0] acc_sat;

  always_comb begin
    is_dec = (ch >= "0") && (ch <= "9");
    is_oct = (ch >= "0") && (ch <= "7");
    is_hex = is_dec || ((ch >= "a") && (ch <= "f")) || ((ch >= "A") && (ch <= "F"));
    // letters a-f / A-F have low nibble 1..6
    dval = is_dec ? ch[3:0] : (ch[3:0] + 4'd9);

    case (cur.mode)
      RX_DEC:  prod = {1'b0, cur.accum, 3'b000} + {3'b000, cur.accum, 1'b0};
      RX_OCT:  prod = {1'b0, cur.accum, 3'b000};
      default: prod = {cur.accum, 4'b0000};
    endcase
    sum     = prod + 36'(dval);
    acc_sat = (|sum[35:32]) ? 32'hFFFF_FFFF : sum[31:0];

    upd = cur;
    unique case (cur.mode)
      RX_START, RX_SIGN: begin
        if (cur.mode == RX_START && ch == "+") begin
          upd.mode = RX_SIGN;
        end else if (cur.mode == RX_START && ch == "-") begin
          upd.negative = 1'b1;
          upd.mode     = RX_SIGN;
        end else if (ch == "0") begin
          upd.mode = RX_ZERO;
        end else if (is_dec) begin
          upd.accum = 32'(dval);
          upd.mode  = RX_DEC;
        end else begin
          upd.mode = RX_STOP;
        end
      end
      RX_ZERO: begin
        if (ch == "x" || ch == "X") begin
          upd.mode = RX_HEX0;
        end else if (is_oct) begin
          upd.accum = 32'(dval);
          upd.mode  = RX_OCT;
        end else begin
          upd.mode = RX_STOP;
        end
      end
      RX_HEX0: begin
        if (is_hex) begin
          upd.accum = 32'(dval);
          upd.mode  = RX_HEX;
        end else begin
          upd.mode = RX_STOP;
        end
      end
      RX_DEC: begin
        if (is_dec) upd.accum = acc_sat;
        else        upd.mode  = RX_STOP;
      end
      RX_OCT: begin
        if (is_oct) upd.accum = acc_sat;
        else        upd.mode  = RX_STOP;
      end
      RX_HEX: begin
        if (is_hex) upd.accum = acc_sat;
        else        upd.mode  = RX_STOP;
      end
      RX_STOP: begin
        upd = cur;
      end
      default: begin
        upd = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/http_request_tokenizer.sv -----
// HTTP request tokenizer top level: input register, byte classifier, result register.
// A byte held in the input register is classified, and its result is registered on tok_valid
// when the output is not stalled. Throughput: one byte per cycle while the output is not
// stalled; the parse state updates on the same edge that loads the result register.
// Reset (rst, synchronous): clears both valid flags and returns the parser to the
// leading-whitespace phase with all counters and the length parser cleared.
`timescale 1ns / 1ps
`default_nettype none

module http_request_tokenizer
  import htok_pkg::*;
#(
  parameter int METHOD_MAX   = METHOD_MAX_DEF,
  parameter int URL_MAX      = URL_MAX_DEF,
  parameter int PROTOCOL_MAX = PROTOCOL_MAX_DEF,
  parameter int QUERY_MAX    = QUERY_MAX_DEF,
  parameter int QUERY_SLOTS  = QUERY_SLOTS_DEF,
  parameter int HEADER_MAX   = HEADER_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req_item,
  output logic      tok_valid,
  input  logic      tok_stall,
  output tok_item_t tok_item
);

  localparam int MAX_A  = (METHOD_MAX > URL_MAX) ? METHOD_MAX : URL_MAX;
  localparam int MAX_B  = (PROTOCOL_MAX > QUERY_MAX) ? PROTOCOL_MAX : QUERY_MAX;
  localparam int MAX_C  = (MAX_A > MAX_B) ? MAX_A : MAX_B;
  localparam int MAX_FC = (MAX_C > HEADER_MAX) ? MAX_C : HEADER_MAX;
  localparam int FC_W   = $clog2(MAX_FC + 1);
  localparam int QI_W   = $clog2(QUERY_SLOTS + 1);

  localparam logic [FC_W-1:0] METHOD_LIM   = FC_W'(METHOD_MAX);
  localparam logic [FC_W-1:0] URL_LIM      = FC_W'(URL_MAX);
  localparam logic [FC_W-1:0] PROTOCOL_LIM = FC_W'(PROTOCOL_MAX);
  localparam logic [FC_W-1:0] QUERY_LIM    = FC_W'(QUERY_MAX);
  localparam logic [FC_W-1:0] HEADER_LIM   = FC_W'(HEADER_MAX);
  localparam logic [QI_W-1:0] SLOT_LIM     = QI_W'(QUERY_SLOTS);

  // parse phases
  localparam logic [3:0] PH_SKIP0  = 4'd0;
  localparam logic [3:0] PH_METHOD = 4'd1;
  localparam logic [3:0] PH_SKIP1  = 4'd2;
  localparam logic [3:0] PH_URL    = 4'd3;
  localparam logic [3:0] PH_QUERY  = 4'd4;
  localparam logic [3:0] PH_SKIP2  = 4'd5;
  localparam logic [3:0] PH_PROTO  = 4'd6;
  localparam logic [3:0] PH_SKIP3  = 4'd7;
  localparam logic [3:0] PH_KEY    = 4'd8;
  localparam logic [3:0] PH_SKIP4  = 4'd9;
  localparam logic [3:0] PH_VALUE  = 4'd10;
  localparam logic [3:0] PH_LINE   = 4'd11;
  localparam logic [3:0] PH_HEND   = 4'd12;
  localparam logic [3:0] PH_BODY   = 4'd13;

  // input register
  logic      req_q_valid;
  req_item_t req_q;
  logic      advance;
  logic      fire;

  // parser state
  logic [3:0]      phase, phase_next;
  logic [FC_W-1:0] field_count, field_count_next;
  logic [QI_W-1:0] query_index, query_index_next;
  logic [3:0]      key_pos, key_pos_next;
  logic            key_ok, key_ok_next;
  logic            is_len, is_len_next;
  num_state_t      num, num_next;
  logic [31:0]     body_remaining, body_remaining_next;
  logic            finished, finished_next;

  // after a whitespace skip or a line start, the phase the byte lands in
  logic [3:0]      ph_e;
  logic [FC_W-1:0] fc_e;
  logic [3:0]      kp_e;
  logic            ko_e;
  logic            il_e;

  logic [7:0]      c;
  logic            sp;
  logic            bad;
  num_state_t      num_fed;
  logic [QI_W+2:0] qi_ext;
  logic [2:0]      slot;
  tok_item_t       res;

  assign advance   = !tok_valid || !tok_stall;
  assign req_stall = req_q_valid && !advance;
  assign fire      = req_q_valid && advance;

  assign c      = req_q.data_byte;
  assign sp     = (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  assign qi_ext = (QI_W + 3)'(query_index);
  assign slot   = qi_ext[2:0];

  htok_num u_num (
    .cur (num),
    .ch  (c),
    .upd (num_fed)
  );

  always_comb begin
    ph_e = phase;
    fc_e = field_count;
    kp_e = key_pos;
    ko_e = key_ok;
    il_e = is_len;
    unique case (phase)
      PH_SKIP0, PH_SKIP1, PH_SKIP2, PH_SKIP4: begin
        if (!sp) begin
          ph_e = phase + 4'd1;
          fc_e = '0;
        end
      end
      PH_SKIP3: begin
        if (!sp) begin
          ph_e = PH_KEY;
          fc_e = '0;
          kp_e = '0;
          ko_e = 1'b1;
          il_e = 1'b0;
        end
      end
      PH_LINE: begin
        if (c != CH_CR && c != CH_LF) begin
          ph_e = PH_KEY;
          fc_e = '0;
          kp_e = '0;
          ko_e = 1'b1;
          il_e = 1'b0;
        end
      end
      PH_HEND: begin
        if (c != CH_LF) begin
          ph_e = PH_KEY;
          fc_e = '0;
          kp_e = '0;
          ko_e = 1'b1;
          il_e = 1'b0;
        end
      end
      default: begin
        ph_e = phase;
      end
    endcase
  end

  always_comb begin
    phase_next          = ph_e;
    field_count_next    = fc_e;
    query_index_next    = query_index;
    key_pos_next        = kp_e;
    key_ok_next         = ko_e;
    is_len_next         = il_e;
    num_next            = num;
    body_remaining_next = body_remaining;
    finished_next       = finished;
    bad                 = 1'b0;

    res.field_kind   = KIND_NONE;
    res.field_byte   = 8'h00;
    res.query_slot   = 3'd0;
    res.field_end    = 1'b0;
    res.request_done = 1'b0;
    res.error_code   = ERR_NONE;
    res.body_length  = 32'd0;

    if (req_q.end_of_stream) begin
      if (!finished) begin
        res.request_done = 1'b1;
        if (phase == PH_BODY && field_count != '0) begin
          res.field_kind = KIND_BODY_QUERY;
          res.query_slot = slot;
          res.field_end  = 1'b1;
        end
      end
      phase_next          = PH_SKIP0;
      field_count_next    = '0;
      query_index_next    = '0;
      key_pos_next        = '0;
      key_ok_next         = 1'b1;
      is_len_next         = 1'b0;
      num_next.mode       = RX_START;
      num_next.accum      = 32'd0;
      num_next.negative   = 1'b0;
      body_remaining_next = 32'd0;
      finished_next       = 1'b0;
    end else if (!finished) begin
      unique case (ph_e)
        PH_METHOD: begin
          if (sp) begin
            res.field_kind = KIND_METHOD;
            res.field_end  = 1'b1;
            phase_next     = PH_SKIP1;
          end else if (fc_e >= METHOD_LIM) begin
            res.error_code = ERR_METHOD;
            finished_next  = 1'b1;
          end else begin
            res.field_kind   = KIND_METHOD;
            res.field_byte   = c;
            field_count_next = fc_e + FC_W'(1);
          end
        end
        PH_URL: begin
          if (sp) begin
            res.field_kind = KIND_URL;
            res.field_end  = 1'b1;
            phase_next     = PH_SKIP2;
          end else if (c == CH_QMARK) begin
            res.field_kind   = KIND_URL;
            res.field_end    = 1'b1;
            phase_next       = PH_QUERY;
            field_count_next = '0;
          end else if (fc_e >= URL_LIM) begin
            res.error_code = ERR_URL;
            finished_next  = 1'b1;
          end else begin
            res.field_kind   = KIND_URL;
            res.field_byte   = c;
            field_count_next = fc_e + FC_W'(1);
          end
        end
        PH_QUERY: begin
          if (sp || c == CH_AMP) begin
            if (query_index >= SLOT_LIM) begin
              res.error_code = ERR_URL_QUERY;
              finished_next  = 1'b1;
            end else begin
              res.field_kind   = KIND_URL_QUERY;
              res.query_slot   = slot;
              res.field_end    = 1'b1;
              query_index_next = query_index + QI_W'(1);
              field_count_next = '0;
              if (sp) phase_next = PH_SKIP2;
            end
          end else if (query_index >= SLOT_LIM || fc_e >= QUERY_LIM) begin
            res.error_code = ERR_URL_QUERY;
            finished_next  = 1'b1;
          end else begin
            res.field_kind   = KIND_URL_QUERY;
            res.field_byte   = c;
            res.query_slot   = slot;
            field_count_next = fc_e + FC_W'(1);
          end
        end
        PH_PROTO: begin
          if (sp) begin
            res.field_kind = KIND_PROTOCOL;
            res.field_end  = 1'b1;
            phase_next     = PH_SKIP3;
          end else if (fc_e >= PROTOCOL_LIM) begin
            res.error_code = ERR_PROTOCOL;
            finished_next  = 1'b1;
          end else begin
            res.field_kind   = KIND_PROTOCOL;
            res.field_byte   = c;
            field_count_next = fc_e + FC_W'(1);
          end
        end
        PH_KEY: begin
          if (c == CH_COLON) begin
            res.field_kind = KIND_KEY;
            res.field_end  = 1'b1;
            is_len_next    = ko_e && (kp_e == LEN_KEY_SIZE);
            if (ko_e && (kp_e == LEN_KEY_SIZE)) begin
              num_next.mode     = RX_START;
              num_next.accum    = 32'd0;
              num_next.negative = 1'b0;
            end
            phase_next = PH_SKIP4;
          end else if (fc_e >= HEADER_LIM) begin
            res.error_code = ERR_KEY;
            finished_next  = 1'b1;
          end else begin
            res.field_kind   = KIND_KEY;
            res.field_byte   = c;
            field_count_next = fc_e + FC_W'(1);
            if (kp_e < LEN_KEY_SIZE && c == len_key_char(kp_e)) begin
              key_pos_next = kp_e + 4'd1;
            end else begin
              key_ok_next = 1'b0;
            end
          end
        end
        PH_VALUE: begin
          if (c == CH_CR) begin
            res.field_kind = KIND_VALUE;
            res.field_end  = 1'b1;
            if (il_e) begin
              num_next.accum      = num.negative ? 32'd0 : num.accum;
              num_next.negative   = 1'b0;
              body_remaining_next = num.negative ? 32'd0 : num.accum;
            end
            phase_next = PH_LINE;
          end else if (fc_e >= HEADER_LIM) begin
            res.error_code = ERR_VALUE;
            finished_next  = 1'b1;
          end else begin
            res.field_kind   = KIND_VALUE;
            res.field_byte   = c;
            field_count_next = fc_e + FC_W'(1);
            if (il_e) num_next = num_fed;
          end
        end
        PH_LINE: begin
          if (c == CH_CR) phase_next = PH_HEND;
        end
        PH_HEND: begin
          // only a LF stays here; anything else already moved to the key phase
          if (body_remaining != 32'd0) begin
            phase_next       = PH_BODY;
            field_count_next = '0;
          end else begin
            res.request_done = 1'b1;
            finished_next    = 1'b1;
          end
        end
        PH_BODY: begin
          if (body_remaining != 32'd0) body_remaining_next = body_remaining - 32'd1;
          if (c == CH_AMP || c == CH_CR) begin
            if (query_index >= SLOT_LIM) begin
              bad = 1'b1;
            end else begin
              res.field_kind   = KIND_BODY_QUERY;
              res.query_slot   = slot;
              res.field_end    = 1'b1;
              query_index_next = query_index + QI_W'(1);
              field_count_next = '0;
            end
          end else if (c != CH_LF) begin
            if (query_index >= SLOT_LIM || fc_e >= QUERY_LIM) begin
              bad = 1'b1;
            end else begin
              res.field_kind   = KIND_BODY_QUERY;
              res.field_byte   = c;
              res.query_slot   = slot;
              field_count_next = fc_e + FC_W'(1);
            end
          end
          if (bad) begin
            res.error_code = ERR_BODY_QUERY;
            finished_next  = 1'b1;
          end else if (body_remaining_next == 32'd0) begin
            // last body byte closes its own slot
            if (res.field_kind == KIND_BODY_QUERY) res.field_end = 1'b1;
            res.request_done = 1'b1;
            finished_next    = 1'b1;
          end
        end
        default: begin
          // still skipping whitespace
          phase_next = ph_e;
        end
      endcase
    end

    if (res.request_done) begin
      res.body_length = num_next.negative ? 32'd0 : num_next.accum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (!req_stall) begin
      req_q_valid <= req_valid;
    end
    if (!req_stall && req_valid) begin
      req_q <= req_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (advance) begin
      tok_valid <= req_q_valid;
    end
    if (fire) begin
      tok_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SKIP0;
      field_count    <= '0;
      query_index    <= '0;
      key_pos        <= '0;
      key_ok         <= 1'b1;
      is_len         <= 1'b0;
      num.mode       <= RX_START;
      num.accum      <= 32'd0;
      num.negative   <= 1'b0;
      body_remaining <= 32'd0;
      finished       <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      field_count    <= field_count_next;
      query_index    <= query_index_next;
      key_pos        <= key_pos_next;
      key_ok         <= key_ok_next;
      is_len         <= is_len_next;
      num            <= num_next;
      body_remaining <= body_remaining_next;
      finished       <= finished_next;
    end
  end

endmodule

`default_nettype wire
